/* src/sda_pkg.sv */
// Package for the signed decimal add/subtract block: request and response
// structs, sizing constants, the digit helper and the shared unit's control struct.
// Depends on nothing.
package sda_pkg;

   localparam int MAX_DIGITS = 32;
   localparam int DIGIT_W    = 4;
   localparam int ADDR_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_a;
      logic [DIGIT_W-1:0] digit_b;
      logic               negative_a;
      logic               negative_b;
      logic               operation;
      logic               final_pair;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] result_digit;
      logic               result_negative;
      logic               result_last;
      logic               digits_dropped;
   } rsp_type;

   // One stored digit pair.
   typedef struct packed {
      logic [DIGIT_W-1:0] a;
      logic [DIGIT_W-1:0] b;
   } pair_type;

   // Control for the shared digit unit.
   typedef struct packed {
      logic subtract;
      logic carry_in;
   } alu_ctl_type;

   // Digit codes above nine saturate to nine.
   function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
      clamp_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

endpackage

/* src/sda_digit_alu.sv */
// Shared single-digit decimal unit: x + y + carry or x - y - borrow, base ten.
// Depends on sda_pkg.
module sda_digit_alu (
   input  logic [sda_pkg::DIGIT_W-1:0] x,
   input  logic [sda_pkg::DIGIT_W-1:0] y,
   input  sda_pkg::alu_ctl_type        ctl,
   output logic [sda_pkg::DIGIT_W-1:0] digit,
   output logic                        carry_out
);

   logic [sda_pkg::DIGIT_W:0] sum;
   logic [sda_pkg::DIGIT_W:0] diff;
   logic [sda_pkg::DIGIT_W:0] fixed;

   always_comb begin
      sum   = {1'b0, x} + {1'b0, y} + {{sda_pkg::DIGIT_W{1'b0}}, ctl.carry_in};
      diff  = {1'b0, x} - {1'b0, y} - {{sda_pkg::DIGIT_W{1'b0}}, ctl.carry_in};
      fixed = '0;
      if (ctl.subtract) begin
         // A negative difference wraps and sets the top bit; add ten back.
         carry_out = diff[sda_pkg::DIGIT_W];
         fixed     = carry_out ? (diff + sda_pkg::RADIX) : diff;
      end else begin
         carry_out = (sum >= sda_pkg::RADIX);
         fixed     = carry_out ? (sum - sda_pkg::RADIX) : sum;
      end
      digit = fixed[sda_pkg::DIGIT_W-1:0];
   end

endmodule

/* src/sda_operand_ram.sv */
// Operand storage: one digit pair per entry, one write and one registered read per cycle.
// Depends on sda_pkg.
module sda_operand_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [sda_pkg::ADDR_W-1:0] wr_addr,
   input  sda_pkg::pair_type          wr_data,
   input  logic [sda_pkg::ADDR_W-1:0] rd_addr,
   output sda_pkg::pair_type          rd_data
);

   sda_pkg::pair_type mem [sda_pkg::MAX_DIGITS];
   sda_pkg::pair_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

/* src/signed_decimal_add_sub.sv */
// Signed-magnitude decimal adder/subtractor. Digit-pair requests are taken only while idle.
// The final request then starts a magnitude compare (only when signs differ), the digit
// arithmetic and the output of up to n+1 result digits for n stored pairs; every arithmetic
// digit step is a memory read followed by a pass through the one shared digit unit. Result
// digits are registered and leave most significant first; no request is taken until the last.
// Synchronous reset returns to idle with an empty operand count; stores are not cleared.
module signed_decimal_add_sub (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sda_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sda_pkg::rsp_type rsp_data
);

   localparam int CW = sda_pkg::CNT_W;
   localparam int AW = sda_pkg::ADDR_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_ARITH = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic          phase_ff, phase_in;      // 0: read issued, 1: read data is valid
   logic [CW-1:0] idx_ff, idx_in;          // digit position being worked on
   logic [CW-1:0] count_ff, count_in;      // stored pairs in this run
   logic          ovf_ff, ovf_in;          // a pair was dropped in this run
   logic          neg_a_ff, neg_a_in;
   logic          neg_b_ff, neg_b_in;      // sign of b after the operation is applied
   logic          sub_ff, sub_in;          // signs differ: magnitudes are subtracted
   logic          a_big_ff, a_big_in;      // |a| >= |b|
   logic          carry_ff, carry_in;
   logic [CW-1:0] top_ff, top_in;          // highest nonzero result digit
   logic          any_ff, any_in;          // some result digit is nonzero
   logic          rsp_strobe_ff, rsp_strobe_in;
   sda_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [sda_pkg::DIGIT_W-1:0] res_mem [sda_pkg::MAX_DIGITS];
   logic [sda_pkg::DIGIT_W-1:0] res_rd_ff;

   logic                        accept;
   logic                        op_wr_en;
   sda_pkg::pair_type           op_wr_data;
   sda_pkg::pair_type           op_rd;
   logic                        res_wr_en;
   logic [sda_pkg::DIGIT_W-1:0] alu_x, alu_y, alu_digit;
   logic                        alu_carry;
   sda_pkg::alu_ctl_type        alu_ctl;
   logic                        neg_b_eff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign neg_b_eff = req_data.negative_b ^ req_data.operation;

   assign op_wr_en   = accept && (count_ff < CW'(sda_pkg::MAX_DIGITS));
   assign op_wr_data = '{a: sda_pkg::clamp_digit(req_data.digit_a),
                         b: sda_pkg::clamp_digit(req_data.digit_b)};

   sda_operand_ram u_operands (
      .clock   (clock),
      .wr_en   (op_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (op_wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (op_rd)
   );

   // The larger magnitude always goes in as the minuend; for addition a_big stays set.
   assign alu_x            = a_big_ff ? op_rd.a : op_rd.b;
   assign alu_y            = a_big_ff ? op_rd.b : op_rd.a;
   assign alu_ctl.subtract = sub_ff;
   assign alu_ctl.carry_in = carry_ff;

   sda_digit_alu u_alu (
      .x         (alu_x),
      .y         (alu_y),
      .ctl       (alu_ctl),
      .digit     (alu_digit),
      .carry_out (alu_carry)
   );

   assign res_wr_en = (state_ff == ST_ARITH) && phase_ff;

   // Result digits, least significant at index zero. A final carry of an addition is
   // not stored; it is produced directly when the output walk reaches index n.
   always_ff @(posedge clock) begin
      if (res_wr_en) begin
         res_mem[idx_ff[AW-1:0]] <= alu_digit;
      end
      res_rd_ff <= res_mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      neg_a_in      = neg_a_ff;
      neg_b_in      = neg_b_ff;
      sub_in        = sub_ff;
      a_big_in      = a_big_ff;
      carry_in      = carry_ff;
      top_in        = top_ff;
      any_in        = any_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.final_pair) begin
                  neg_a_in = req_data.negative_a;
                  neg_b_in = neg_b_eff;
                  sub_in   = (req_data.negative_a != neg_b_eff);
                  a_big_in = 1'b1;
                  carry_in = 1'b0;
                  top_in   = '0;
                  any_in   = 1'b0;
                  phase_in = 1'b0;
                  if (req_data.negative_a != neg_b_eff) begin
                     // Compare from the most significant stored digit downward.
                     state_in = ST_CMP;
                     idx_in   = count_in - CW'(1);
                  end else begin
                     state_in = ST_ARITH;
                     idx_in   = '0;
                  end
               end
            end
         end

         ST_CMP: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (op_rd.a != op_rd.b) begin
                  a_big_in = (op_rd.a > op_rd.b);
                  state_in = ST_ARITH;
                  idx_in   = '0;
               end else if (idx_ff == '0) begin
                  // Equal magnitudes: the difference is zero and comes out positive.
                  state_in = ST_ARITH;
               end else begin
                  idx_in = idx_ff - CW'(1);
               end
            end
         end

         ST_ARITH: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               carry_in = alu_carry;
               if (alu_digit != '0) begin
                  top_in = idx_ff;
                  any_in = 1'b1;
               end
               if (idx_ff == count_ff - CW'(1)) begin
                  if (!sub_ff && alu_carry) begin
                     top_in = count_ff;
                     any_in = 1'b1;
                  end
                  state_in = ST_EMIT;
                  idx_in   = top_in;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end

         ST_EMIT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               rsp_strobe_in                = 1'b1;
               rsp_data_in.result_digit     = (idx_ff == count_ff) ? sda_pkg::DIGIT_W'(1)
                                                                   : res_rd_ff;
               rsp_data_in.result_negative  = any_ff && (a_big_ff ? neg_a_ff : neg_b_ff);
               rsp_data_in.result_last      = (idx_ff == '0);
               rsp_data_in.digits_dropped   = ovf_ff;
               if (idx_ff == '0) begin
                  // Run complete: the block is ready for the next operand pair.
                  state_in = ST_IDLE;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  idx_in = idx_ff - CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff      <= idx_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      sub_ff      <= sub_in;
      a_big_ff    <= a_big_in;
      carry_ff    <= carry_in;
      top_ff      <= top_in;
      any_ff      <= any_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The last digit of a run leaves the sequencer idle; earlier digits keep it busy.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.result_last |-> !busy)
      else $error("block still busy after the last result digit");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.result_last |-> busy)
      else $error("block went idle in the middle of a result");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.result_digit <= sda_pkg::DIGIT_MAX)
      else $error("result digit is not decimal");

   a_load_only: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.final_pair |=> !busy && !rsp_strobe)
      else $error("a non-final request started work");

endmodule
